### rtl/sfp_pkg.sv
// Package for the sensor frame packer: byte sequencer phase type, frame
// constants and the CRC-16 byte update. No dependencies.
package sfp_pkg;

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN,
        PH_TYPE,
        PH_SRC,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    localparam logic [7:0]  SYNC0_BYTE = 8'hAA;
    localparam logic [7:0]  SYNC1_BYTE = 8'h55;
    localparam logic [7:0]  TYPE_BYTE  = 8'h01;
    localparam logic [7:0]  LEN_OFFSET = 8'd5;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/sensor_frame_packer_crc16.sv
// Top level of the sensor frame packer: takes payload bytes and emits framed
// bytes with sync header and CRC-16. Depends on sfp_pkg.
//
// Each accepted payload byte is held in an item register while a phase
// sequencer emits its frame bytes into the output register, one byte per
// cycle unless m_ready holds the output: six on the first byte of a
// message (sync, sync, length, type, source, data), one on a middle byte,
// and two more CRC bytes on the last. The next item is accepted in the
// cycle its final byte enters the output register. The CRC is advanced
// one byte per cycle while frame bytes are emitted.
module sensor_frame_packer_crc16 #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_source_id,
    input  logic [4:0] s_payload_len,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_frame_end
);

    logic            busy_reg, busy_next;
    sfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      data_reg, data_next;
    logic [7:0]      src_reg, src_next;
    logic [7:0]      lenbyte_reg, lenbyte_next;
    logic            in_message_reg, in_message_next;
    logic [4:0]      bytes_seen_reg, bytes_seen_next;
    logic [4:0]      expected_len_reg, expected_len_next;
    logic [15:0]     crc_reg, crc_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_frame_byte_reg, m_frame_byte_next;
    logic            m_frame_end_reg, m_frame_end_next;

    logic       load;
    logic       last_phase;
    logic       msg_last;
    logic       accept;
    logic [5:0] seen_inc;
    logic [4:0] len_clamped;
    logic [7:0] out_byte;
    logic       out_end;

    assign load       = busy_reg && (!m_valid_reg || m_ready);
    assign seen_inc   = {1'b0, bytes_seen_reg} + 6'd1;
    assign msg_last   = seen_inc >= {1'b0, expected_len_reg};
    assign last_phase = (phase_reg == sfp_pkg::PH_CRC_HI)
                     || ((phase_reg == sfp_pkg::PH_DATA) && !msg_last);
    assign s_ready    = !busy_reg || (load && last_phase);
    assign accept     = s_valid && s_ready;

    always_comb begin
        len_clamped = (s_payload_len == 5'd0) ? 5'd1 : s_payload_len;
        if (int'(len_clamped) > MAX_PAYLOAD) begin
            len_clamped = 5'(MAX_PAYLOAD);
        end
    end

    always_comb begin
        out_end = 1'b0;
        case (phase_reg)
            sfp_pkg::PH_SYNC0:  out_byte = sfp_pkg::SYNC0_BYTE;
            sfp_pkg::PH_SYNC1:  out_byte = sfp_pkg::SYNC1_BYTE;
            sfp_pkg::PH_LEN:    out_byte = lenbyte_reg;
            sfp_pkg::PH_TYPE:   out_byte = sfp_pkg::TYPE_BYTE;
            sfp_pkg::PH_SRC:    out_byte = src_reg;
            sfp_pkg::PH_DATA:   out_byte = data_reg;
            sfp_pkg::PH_CRC_LO: out_byte = crc_reg[7:0];
            sfp_pkg::PH_CRC_HI: begin
                out_byte = crc_reg[15:8];
                out_end  = 1'b1;
            end
            default:            out_byte = data_reg;
        endcase
    end

    always_comb begin
        busy_next         = busy_reg;
        phase_next        = phase_reg;
        data_next         = data_reg;
        src_next          = src_reg;
        lenbyte_next      = lenbyte_reg;
        in_message_next   = in_message_reg;
        bytes_seen_next   = bytes_seen_reg;
        expected_len_next = expected_len_reg;
        crc_next          = crc_reg;
        m_valid_next      = m_valid_reg;
        m_frame_byte_next = m_frame_byte_reg;
        m_frame_end_next  = m_frame_end_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            m_valid_next      = 1'b1;
            m_frame_byte_next = out_byte;
            m_frame_end_next  = out_end;
            case (phase_reg)
                sfp_pkg::PH_SYNC0:  phase_next = sfp_pkg::PH_SYNC1;
                sfp_pkg::PH_SYNC1:  phase_next = sfp_pkg::PH_LEN;
                sfp_pkg::PH_LEN: begin
                    crc_next   = sfp_pkg::crc_update(crc_reg, out_byte);
                    phase_next = sfp_pkg::PH_TYPE;
                end
                sfp_pkg::PH_TYPE: begin
                    crc_next   = sfp_pkg::crc_update(crc_reg, out_byte);
                    phase_next = sfp_pkg::PH_SRC;
                end
                sfp_pkg::PH_SRC: begin
                    crc_next   = sfp_pkg::crc_update(crc_reg, out_byte);
                    phase_next = sfp_pkg::PH_DATA;
                end
                sfp_pkg::PH_DATA: begin
                    crc_next        = sfp_pkg::crc_update(crc_reg, out_byte);
                    bytes_seen_next = seen_inc[4:0];
                    if (msg_last) begin
                        phase_next = sfp_pkg::PH_CRC_LO;
                    end else begin
                        busy_next = 1'b0;
                    end
                end
                sfp_pkg::PH_CRC_LO: phase_next = sfp_pkg::PH_CRC_HI;
                sfp_pkg::PH_CRC_HI: begin
                    busy_next         = 1'b0;
                    in_message_next   = 1'b0;
                    bytes_seen_next   = 5'd0;
                    expected_len_next = 5'd0;
                    crc_next          = sfp_pkg::CRC_INIT;
                end
                default:            phase_next = sfp_pkg::PH_DATA;
            endcase
        end

        if (accept) begin
            busy_next = 1'b1;
            data_next = s_data_byte;
            if (!in_message_next) begin
                phase_next        = sfp_pkg::PH_SYNC0;
                src_next          = s_source_id;
                lenbyte_next      = {3'b000, len_clamped} + sfp_pkg::LEN_OFFSET;
                expected_len_next = len_clamped;
                bytes_seen_next   = 5'd0;
                in_message_next   = 1'b1;
                crc_next          = sfp_pkg::CRC_INIT;
            end else begin
                phase_next = sfp_pkg::PH_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            phase_reg        <= sfp_pkg::PH_DATA;
            in_message_reg   <= 1'b0;
            bytes_seen_reg   <= 5'd0;
            expected_len_reg <= 5'd0;
            crc_reg          <= sfp_pkg::CRC_INIT;
            m_valid_reg      <= 1'b0;
        end else begin
            busy_reg         <= busy_next;
            phase_reg        <= phase_next;
            in_message_reg   <= in_message_next;
            bytes_seen_reg   <= bytes_seen_next;
            expected_len_reg <= expected_len_next;
            crc_reg          <= crc_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg         <= data_next;
        src_reg          <= src_next;
        lenbyte_reg      <= lenbyte_next;
        m_frame_byte_reg <= m_frame_byte_next;
        m_frame_end_reg  <= m_frame_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_frame_end  = m_frame_end_reg;

    a_crc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_message_reg |-> (crc_reg == sfp_pkg::CRC_INIT))
        else $error("crc not at init value outside a message");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_message_reg |-> (bytes_seen_reg <= expected_len_reg))
        else $error("payload count passed length inside a message");

    a_crc_in_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (phase_reg == sfp_pkg::PH_CRC_HI)) |-> in_message_reg)
        else $error("crc byte emitted outside a message");

endmodule

### sim/sfp_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for sensor_frame_packer_crc16: watches both channels, predicts the
// framed byte stream with its own CRC-16 and compares it byte by byte.
// Depends on sfp_pkg for the frame constants.
module sfp_frame_checker #(
    parameter int MAX_LEN = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_source_id,
    input  logic [4:0] s_payload_len,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_frame_byte,
    input  logic       m_frame_end,
    output int         fail_count,
    output int         bytes_pending
);

    localparam int MAX_REPORTS = 50;

    typedef struct {
        logic [7:0] fbyte;
        logic       last;
    } frame_byte_t;

    frame_byte_t frame_q[$];

    logic        msg_open;
    logic [4:0]  msg_len;
    logic [4:0]  msg_count;
    logic [15:0] frame_crc;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        msb;
        acc = crc ^ {b, 8'h00};
        repeat (8) begin
            msb = acc[15];
            acc = acc << 1;
            if (msb) begin
                acc = acc ^ sfp_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS) begin
            $display("ERROR %0t ns: %s", $time, what);
        end
        fail_count++;
    endtask

    task automatic queue_frame_byte(input logic [7:0] b, input logic last);
        frame_byte_t fb;
        fb.fbyte = b;
        fb.last  = last;
        frame_q.push_back(fb);
    endtask

    task automatic frame_payload_byte(input logic [7:0] data, input logic [7:0] src,
                                      input logic [4:0] len);
        logic [7:0] len_byte;
        if (!msg_open) begin
            if (len == 5'd0) begin
                msg_len = 5'd1;
            end else if (len > MAX_LEN) begin
                msg_len = 5'(MAX_LEN);
            end else begin
                msg_len = len;
            end
            msg_count = 5'd0;
            msg_open  = 1'b1;
            len_byte  = 8'(msg_len) + sfp_pkg::LEN_OFFSET;
            queue_frame_byte(sfp_pkg::SYNC0_BYTE, 1'b0);
            queue_frame_byte(sfp_pkg::SYNC1_BYTE, 1'b0);
            queue_frame_byte(len_byte, 1'b0);
            queue_frame_byte(sfp_pkg::TYPE_BYTE, 1'b0);
            queue_frame_byte(src, 1'b0);
            frame_crc = crc16_next(sfp_pkg::CRC_INIT, len_byte);
            frame_crc = crc16_next(frame_crc, sfp_pkg::TYPE_BYTE);
            frame_crc = crc16_next(frame_crc, src);
        end
        queue_frame_byte(data, 1'b0);
        frame_crc = crc16_next(frame_crc, data);
        msg_count = msg_count + 5'd1;
        if (msg_count >= msg_len) begin
            queue_frame_byte(frame_crc[7:0], 1'b0);
            queue_frame_byte(frame_crc[15:8], 1'b1);
            msg_open  = 1'b0;
            msg_count = 5'd0;
            msg_len   = 5'd0;
            frame_crc = sfp_pkg::CRC_INIT;
        end
    endtask

    task automatic check_frame_byte();
        frame_byte_t fb;
        if (frame_q.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %02h end %0b",
                                      m_frame_byte, m_frame_end));
        end else begin
            fb = frame_q.pop_front();
            if (m_frame_byte !== fb.fbyte) begin
                report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                          m_frame_byte, fb.fbyte));
            end
            if (m_frame_end !== fb.last) begin
                report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                          m_frame_end, fb.last, fb.fbyte));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            msg_open  = 1'b0;
            msg_count = 5'd0;
            msg_len   = 5'd0;
            frame_crc = sfp_pkg::CRC_INIT;
            frame_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                frame_payload_byte(s_data_byte, s_source_id, s_payload_len);
            end
            if (m_valid && m_ready) begin
                check_frame_byte();
            end
        end
        bytes_pending <= frame_q.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for sensor_frame_packer_crc16: drives payload byte transactions
// with random idling and a long output hold-off, and gives the verdict.
// Depends on the block and sfp_frame_checker.
module tb_top;

    localparam int MAX_LEN        = 16;
    localparam int TOTAL_ITEMS    = 360;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic [7:0] s_source_id;
    logic [4:0] s_payload_len;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_frame_byte;
    logic       m_frame_end;

    int fail_count;
    int bytes_pending;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int quiet_cycles;
    bit long_hold_req;

    sensor_frame_packer_crc16 #(
        .MAX_PAYLOAD(MAX_LEN)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_source_id  (s_source_id),
        .s_payload_len(s_payload_len),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end)
    );

    sfp_frame_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_source_id  (s_source_id),
        .s_payload_len(s_payload_len),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end),
        .fail_count   (fail_count),
        .bytes_pending(bytes_pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic [7:0] src,
                             input logic [4:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= data;
        s_source_id   <= src;
        s_payload_len <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_message(input logic [7:0] first_data, input logic [7:0] src,
                                input logic [4:0] len_field);
        int n;
        n = (len_field == 5'd0) ? 1 : ((len_field > MAX_LEN) ? MAX_LEN : len_field);
        send_byte(first_data, src, len_field);
        // vary source and length mid-message; the block must ignore them
        for (int i = 1; i < n; i++) begin
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)),
                      5'($urandom_range(31)));
        end
    endtask

    initial begin
        int         roll;
        logic [4:0] len_field;
        items_sent    = 0;
        long_hold_req = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 61;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data_byte   <= 8'h00;
        s_source_id   <= 8'h00;
        s_payload_len <= 5'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_message(8'h00, 8'h00, 5'd0);
        send_message(8'hFF, 8'hFF, 5'd1);
        send_message(8'h5A, 8'hA5, 5'd31);
        send_message(8'h00, 8'h3C, 5'd2);

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
                if (send_idle_pct != 0) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold_req = 1'b1;
                end
            end else if (items_sent >= TOTAL_ITEMS / 3) begin
                send_idle_pct = 61;
                recv_idle_pct = 24;
            end
            roll = $urandom_range(99);
            if (roll < 80) begin
                len_field = 5'($urandom_range(6, 1));
            end else if (roll < 90) begin
                len_field = 5'($urandom_range(16, 7));
            end else if (roll < 95) begin
                len_field = 5'd0;
            end else begin
                len_field = 5'($urandom_range(31, 17));
            end
            send_message(8'($urandom_range(255)), 8'($urandom_range(255)), len_field);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (bytes_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
